// ----- src/bcrr_pkg.sv -----
`timescale 1ns / 1ps
package bcrr_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int QSHIFT = 16;
  localparam int MAX_FACTOR = 64;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_COEF   = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SLOT_B0   = 3'd0,
    SLOT_B1   = 3'd1,
    SLOT_B2   = 3'd2,
    SLOT_A0   = 3'd3,
    SLOT_A1   = 3'd4,
    SLOT_A2   = 3'd5,
    SLOT_GAIN = 3'd6
  } slot_t;

  typedef enum logic [1:0] {
    CFG_UP       = 2'd0,
    CFG_DOWN     = 2'd1,
    CFG_SECTIONS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_COUNT = 2'd1,
    ST_ISSUE = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] v;
    logic        emit;
    logic        last;
  } link_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  slot;
    logic [31:0] value;
  } coef_wr_t;

endpackage

// ----- src/bcrr_cell.sv -----
`timescale 1ns / 1ps
module bcrr_cell import bcrr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     active,
  input  coef_wr_t coef_wr,
  input  link_t    up,
  output logic     up_ready,
  output link_t    down,
  input  logic     dn_ready,
  output logic     idle
);

  logic [31:0] c0_r, c1_r, c2_r, c4_r, c5_r, g_r;
  logic        busy_r, busy_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  opk_r, opk_nxt;
  logic        hi_r, hi_nxt;
  logic [47:0] v_r, v_nxt;
  logic        emit_r, emit_nxt, last_r, last_nxt;
  logic [47:0] res_r, res_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [47:0] ov_v_r, ov_v_nxt;
  logic        ov_emit_r, ov_emit_nxt, ov_last_r, ov_last_nxt;

  logic signed [31:0] coef;
  logic        [47:0] opd;
  logic signed [24:0] mul_b;
  logic signed [56:0] prod;
  logic        [63:0] pw, full;
  logic        [31:0] mid;
  logic               accept;

  assign up_ready = !busy_r && !ov_r;
  assign accept   = up.valid && up_ready;
  assign idle     = !busy_r && !ov_r;

  assign down.valid = ov_r;
  assign down.v     = ov_v_r;
  assign down.emit  = ov_emit_r;
  assign down.last  = ov_last_r;

  always_comb begin
    case (opk_r)
      3'd0: coef = c0_r;
      3'd1: coef = c1_r;
      3'd2: coef = c4_r;
      3'd3: coef = c2_r;
      3'd4: coef = c5_r;
      default: coef = g_r;
    endcase
    case (opk_r)
      3'd2, 3'd4: opd = res_r;
      3'd5: opd = {{16{res_r[31]}}, res_r[31:0]};
      default: opd = v_r;
    endcase
  end

  assign mul_b = hi_r ? {opd[47], opd[47:24]} : {1'b0, opd[23:0]};
  assign prod  = coef * mul_b;
  assign pw    = {{7{prod[56]}}, prod};
  assign full  = acc_r + (pw << 24);
  assign mid   = full[47:16];

  always_comb begin
    busy_nxt    = busy_r;
    ov_nxt      = ov_r;
    opk_nxt     = opk_r;
    hi_nxt      = hi_r;
    v_nxt       = v_r;
    emit_nxt    = emit_r;
    last_nxt    = last_r;
    res_nxt     = res_r;
    t_nxt       = t_r;
    d0_nxt      = d0_r;
    d1_nxt      = d1_r;
    acc_nxt     = acc_r;
    ov_v_nxt    = ov_v_r;
    ov_emit_nxt = ov_emit_r;
    ov_last_nxt = ov_last_r;
    if (ov_r && dn_ready) begin
      ov_nxt = 1'b0;
    end
    if (accept) begin
      if (active) begin
        busy_nxt = 1'b1;
        v_nxt    = up.v;
        emit_nxt = up.emit;
        last_nxt = up.last;
        opk_nxt  = 3'd0;
        hi_nxt   = 1'b0;
      end else begin
        ov_nxt      = 1'b1;
        ov_v_nxt    = up.v;
        ov_emit_nxt = up.emit;
        ov_last_nxt = up.last;
      end
    end
    if (busy_r) begin
      if (!hi_r) begin
        acc_nxt = pw;
        hi_nxt  = 1'b1;
      end else begin
        hi_nxt  = 1'b0;
        opk_nxt = opk_r + 3'd1;
        case (opk_r)
          3'd0: res_nxt = full[63:16] + {{16{d0_r[31]}}, d0_r};
          3'd1: t_nxt = mid;
          3'd2: d0_nxt = t_r - mid + d1_r;
          3'd3: t_nxt = mid;
          3'd4: d1_nxt = t_r - mid;
          default: begin
            busy_nxt    = 1'b0;
            ov_nxt      = 1'b1;
            ov_v_nxt    = full[63:16];
            ov_emit_nxt = emit_r;
            ov_last_nxt = last_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      opk_r  <= 3'd0;
      hi_r   <= 1'b0;
      d0_r   <= 32'd0;
      d1_r   <= 32'd0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      opk_r  <= opk_nxt;
      hi_r   <= hi_nxt;
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
    end
    v_r       <= v_nxt;
    emit_r    <= emit_nxt;
    last_r    <= last_nxt;
    res_r     <= res_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    ov_v_r    <= ov_v_nxt;
    ov_emit_r <= ov_emit_nxt;
    ov_last_r <= ov_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (coef_wr.we) begin
      case (coef_wr.slot)
        SLOT_B0:   c0_r <= coef_wr.value;
        SLOT_B1:   c1_r <= coef_wr.value;
        SLOT_B2:   c2_r <= coef_wr.value;
        SLOT_A1:   c4_r <= coef_wr.value;
        SLOT_A2:   c5_r <= coef_wr.value;
        SLOT_GAIN: g_r  <= coef_wr.value;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !up_ready) else $error("cell took an item while busy");
  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> opk_r <= 3'd5) else $error("cell operation out of range");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && hi_r && opk_r == 3'd5) |=> (ov_r && !busy_r))
    else $error("cell result not presented");
`endif

endmodule

// ----- src/biquad_cascade_rational_resampler_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Ports
// in        input      in_valid, in_ready, in_kind, in_sample_in, in_coef_section,
//                      in_coef_slot, in_coef_value
// out       output     out_valid, out_ready, out_sample_out, out_last
// cfg       input      cfg_we, cfg_index, cfg_data
// Coefficient and block-start items are handled on acceptance; a sample first runs a count pass
// over up_factor steps and then feeds up_factor filter steps into the cell chain.
// An unused cell passes a step on through its output register; an active cell takes a new step
// only once it has finished the last one and that result has left its output register.
// Each cell has one 32 by 25 bit multiplier and works on the two 24-bit halves of each
// 48-bit operand in turn.
// Reset is synchronous and clears control state and the delay words.
// A stalled output holds the cell chain; no item is accepted until the chain is empty.
module biquad_cascade_rational_resampler_unit import bcrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic signed [15:0] in_sample_in,
  input  logic [2:0]  in_coef_section,
  input  logic [2:0]  in_coef_slot,
  input  logic signed [31:0] in_coef_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_sample_out,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  ctl_state_t  state_r, state_nxt;
  logic [6:0]  up_r, dn_r;
  logic [3:0]  sec_r;
  logic [6:0]  upe_r, upe_nxt, dne_r, dne_nxt;
  logic [15:0] smp_r, smp_nxt;
  logic [6:0]  step_r, step_nxt, emits_r, emits_nxt, k_r, k_nxt;
  logic [5:0]  scan_r, scan_nxt, phase_r, phase_nxt;
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [31:0] osmp_r, osmp_nxt;

  logic [6:0]  up_eff, dn_eff;
  logic        in_acc, chain_idle, scan_hit, ph_hit, step_end;
  logic [6:0]  scan_inc, ph_inc;
  coef_wr_t    coef_wr;
  link_t       link [MAX_SECTIONS+1];
  logic        rdy  [MAX_SECTIONS+1];
  logic [MAX_SECTIONS-1:0] cell_idle;

  assign up_eff = (up_r > 7'(MAX_FACTOR)) ? 7'(MAX_FACTOR) : up_r;
  assign dn_eff = (dn_r == 7'd0) ? 7'd1 : ((dn_r > 7'(MAX_FACTOR)) ? 7'(MAX_FACTOR) : dn_r);
  assign in_acc = in_valid && in_ready;
  assign chain_idle = &cell_idle;
  assign scan_inc = {1'b0, scan_r} + 7'd1;
  assign ph_inc   = {1'b0, phase_r} + 7'd1;
  assign scan_hit = scan_inc >= dne_r;
  assign ph_hit   = ph_inc >= dne_r;
  assign step_end = step_r == upe_r - 7'd1;

  assign coef_wr.we    = in_acc && in_kind == KIND_COEF &&
                         32'(in_coef_section) < 32'(MAX_SECTIONS);
  assign coef_wr.slot  = in_coef_slot;
  assign coef_wr.value = in_coef_value;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_SAMPLE && up_eff != 7'd0) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (step_end) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (rdy[0] && step_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE) && chain_idle;
    link[0].valid = (state_r == ST_ISSUE);
    link[0].v     = {{16{smp_r[15]}}, smp_r, 16'd0};
    link[0].emit  = ph_hit;
    link[0].last  = ph_hit && (k_r + 7'd1 == emits_r);
  end

  always_comb begin
    upe_nxt   = upe_r;
    dne_nxt   = dne_r;
    smp_nxt   = smp_r;
    step_nxt  = step_r;
    emits_nxt = emits_r;
    k_nxt     = k_r;
    scan_nxt  = scan_r;
    phase_nxt = phase_r;
    if (in_acc) begin
      case (in_kind)
        KIND_SAMPLE: begin
          upe_nxt   = up_eff;
          dne_nxt   = dn_eff;
          smp_nxt   = in_sample_in;
          step_nxt  = 7'd0;
          emits_nxt = 7'd0;
          k_nxt     = 7'd0;
          scan_nxt  = phase_r;
        end
        KIND_START: phase_nxt = 6'd0;
        default: ;
      endcase
    end
    if (state_r == ST_COUNT) begin
      scan_nxt  = scan_hit ? 6'd0 : scan_inc[5:0];
      emits_nxt = emits_r + {6'd0, scan_hit};
      step_nxt  = step_end ? 7'd0 : step_r + 7'd1;
    end
    if (state_r == ST_ISSUE && rdy[0]) begin
      phase_nxt = ph_hit ? 6'd0 : ph_inc[5:0];
      k_nxt     = k_r + {6'd0, ph_hit};
      step_nxt  = step_r + 7'd1;
    end
  end

  for (genvar r = 0; r < MAX_SECTIONS; r++) begin : g_cell
    coef_wr_t cw;
    assign cw.we    = coef_wr.we && 32'(in_coef_section) == r;
    assign cw.slot  = coef_wr.slot;
    assign cw.value = coef_wr.value;
    bcrr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (r < int'(sec_r)),
      .coef_wr  (cw),
      .up       (link[r]),
      .up_ready (rdy[r]),
      .down     (link[r+1]),
      .dn_ready (rdy[r+1]),
      .idle     (cell_idle[r])
    );
  end

  assign rdy[MAX_SECTIONS] = !link[MAX_SECTIONS].emit || !ov_r || out_ready;

  always_comb begin
    ov_nxt    = ov_r && !out_ready;
    osmp_nxt  = osmp_r;
    olast_nxt = olast_r;
    if (link[MAX_SECTIONS].valid && link[MAX_SECTIONS].emit && rdy[MAX_SECTIONS]) begin
      ov_nxt    = 1'b1;
      osmp_nxt  = link[MAX_SECTIONS].v[47:16];
      olast_nxt = link[MAX_SECTIONS].last;
    end
  end

  assign out_valid      = ov_r;
  assign out_sample_out = osmp_r;
  assign out_last       = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      up_r    <= 7'd1;
      dn_r    <= 7'd1;
      sec_r   <= 4'd1;
      phase_r <= 6'd0;
      step_r  <= 7'd0;
      emits_r <= 7'd0;
      k_r     <= 7'd0;
      scan_r  <= 6'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      emits_r <= emits_nxt;
      k_r     <= k_nxt;
      scan_r  <= scan_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_UP:       up_r  <= cfg_data;
          CFG_DOWN:     dn_r  <= cfg_data;
          CFG_SECTIONS: sec_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
    upe_r   <= upe_nxt;
    dne_r   <= dne_nxt;
    smp_r   <= smp_nxt;
    osmp_r  <= osmp_nxt;
    olast_r <= olast_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE && chain_idle)) else $error("ready while busy");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COUNT |-> upe_r != 7'd0) else $error("count pass with no steps");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> k_r <= emits_r) else $error("more results than counted");
`endif

endmodule
